### rtl/led_chase_fade_pwm_controller_core_macros.svh
// Assertion macros used by the checker of the LED chase controller.
// Depends on nothing; included by the checker with a bare file name.
`ifndef LED_CHASE_FADE_PWM_CONTROLLER_CORE_MACROS_SVH
`define LED_CHASE_FADE_PWM_CONTROLLER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define LCFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define LCFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lcfp_pkg.sv
// Package of the LED chase controller: result type, register indexes and fixed constants.
// Depends on nothing; used by the top level and the output buffer.
`timescale 1ns / 1ps

package lcfp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TICKS    = 2'd3;

    // Register values after reset.
    localparam logic [7:0] MAX_DUTY_RST       = 8'd150;
    localparam logic [7:0] PWM_PERIOD_RST     = 8'd150;
    localparam logic [7:0] DEBOUNCE_TICKS_RST = 8'd8;
    localparam logic [7:0] SLEEP_TICKS_RST    = 8'd200;

    // Schedule slot timing, in slow ticks.
    localparam int         OFFSET_W   = 9;
    localparam logic [8:0] SLOT_LAST  = 9'd399;
    localparam logic [8:0] RAMP_TICKS = 9'd150;
    localparam logic [8:0] HOLD_END   = 9'd250;

    // Key hold count saturates here.
    localparam logic [7:0] HOLD_LIMIT = 8'd200;

    localparam int MASK_W = 4;

    typedef struct packed {
        logic [MASK_W-1:0] led_mask;
        logic              power_on;
        logic              sleep_request;
    } t_result;

endpackage

### rtl/lcfp_if.sv
// Handshake interfaces for the input and result channels of the LED chase controller.
// Depends on nothing.
`timescale 1ns / 1ps

interface lcfp_in_if;
    logic valid;
    logic ready;
    logic slow_tick;
    logic key_pressed;

    modport source (output valid, output slow_tick, output key_pressed, input ready);
    modport sink   (input valid, input slow_tick, input key_pressed, output ready);
endinterface

interface lcfp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] led_mask;
    logic       power_on;
    logic       sleep_request;

    modport source (output valid, output led_mask, output power_on,
                    output sleep_request, input ready);
    modport sink   (input valid, input led_mask, input power_on,
                    input sleep_request, output ready);
endinterface

### rtl/lcfp_skid.sv
// Two-entry output buffer: a result register plus a skid register.
// Depends on lcfp_pkg for the result type.
`timescale 1ns / 1ps

module lcfp_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  lcfp_pkg::t_result i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output lcfp_pkg::t_result o_pop_data
);
    import lcfp_pkg::*;

    logic    r_out_valid;
    t_result r_out_data;
    logic    r_skid_valid;
    t_result r_skid_data;
    logic    push;
    logic    pop;

    // The skid entry absorbs one beat while the result register is stalled.
    assign o_push_ready = !r_skid_valid;
    assign push         = i_push_valid && !r_skid_valid;
    assign pop          = r_out_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_data  <= i_push_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= i_push_data;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pop_valid = r_out_valid;
    assign o_pop_data  = r_out_data;

endmodule

### rtl/led_chase_fade_pwm_controller_core.sv
// Top level of the LED chase controller with fade, software PWM and a power key.
// Depends on lcfp_pkg, the interfaces in lcfp_if.sv and lcfp_skid.
//
//   Channel   Direction  Beat contents                             Handshake
//   i_in_ch   in         slow_tick, key_pressed                    valid/ready
//   o_out_ch  out        led_mask, power_on, sleep_request         valid/ready
//   cfg       in         i_cfg_idx, i_cfg_data                     i_cfg_we, no wait
//
// One input beat is one pass of the control loop and is taken every clock cycle
// while the buffer has room; its result beat is registered in the output buffer.
// The loop state updates at the accepting edge through compares, counters and
// selects, so one beat per cycle is sustained while the output is not stalled.
// A two-entry output buffer lets one more beat in while a result is stalled;
// the input side stalls only when both entries are full.
// Reset is synchronous and active low; it clears all state but the result data and
// restores the register defaults: it starts powered off with all duties zero.
`timescale 1ns / 1ps

module led_chase_fade_pwm_controller_core #(
    parameter int LED_CHANNELS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lcfp_in_if.sink                              i_in_ch,
    lcfp_out_if.source                           o_out_ch,
    input  logic                                 i_cfg_we,
    input  logic [lcfp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lcfp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import lcfp_pkg::*;

    localparam int SLOT_W = $clog2(LED_CHANNELS);

    // Configuration registers.
    logic [7:0] r_max_duty;
    logic [7:0] r_pwm_period;
    logic [7:0] r_debounce_ticks;
    logic [7:0] r_sleep_ticks;

    // Loop state. The schedule phase is kept as a slot number and an offset
    // within the 400-tick slot, which avoids dividing the phase by 400.
    logic [7:0]          r_pwm_count;
    logic [7:0]          r_duty [LED_CHANNELS];
    logic [SLOT_W-1:0]   r_slot;
    logic [OFFSET_W-1:0] r_offset;
    logic                r_power;
    logic [7:0]          r_hold;
    logic [7:0]          r_idle;

    logic [7:0]          n_pwm_count;
    logic [7:0]          n_duty [LED_CHANNELS];
    logic [SLOT_W-1:0]   n_slot;
    logic [OFFSET_W-1:0] n_offset;
    logic                n_power;
    logic [7:0]          n_hold;
    logic [7:0]          n_idle;

    logic                in_fire;
    logic                in_ready;
    logic                toggle;
    logic                sched_en;
    logic                in_ramp_up;
    logic                in_hold;
    logic                sleep_req;
    logic [8:0]          pwm_inc;
    logic [7:0]          idle_inc;
    logic [MASK_W-1:0]   led_mask;
    t_result             result;
    t_result             out_data;

    assign in_fire        = i_in_ch.valid && in_ready;
    assign i_in_ch.ready  = in_ready;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty       <= MAX_DUTY_RST;
            r_pwm_period     <= PWM_PERIOD_RST;
            r_debounce_ticks <= DEBOUNCE_TICKS_RST;
            r_sleep_ticks    <= SLEEP_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_DUTY:       r_max_duty       <= i_cfg_data;
                CFG_PWM_PERIOD:     r_pwm_period     <= i_cfg_data;
                CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data;
                CFG_SLEEP_TICKS:    r_sleep_ticks    <= i_cfg_data;
            endcase
        end
    end

    // Channels above the fourth are not shown on the mask; channels that do
    // not exist read as dark. The mask uses the duties before this pass.
    for (genvar k = 0; k < MASK_W; k++) begin : g_mask
        if (k < LED_CHANNELS) begin : g_live
            assign led_mask[k] = r_power && (r_pwm_count < r_duty[k]);
        end else begin : g_dark
            assign led_mask[k] = 1'b0;
        end
    end

    // Key debounce, power toggle, PWM counter, schedule phase and idle timer.
    always_comb begin
        n_pwm_count = r_pwm_count;
        n_hold      = r_hold;
        n_idle      = r_idle;
        n_slot      = r_slot;
        n_offset    = r_offset;
        toggle      = 1'b0;
        sleep_req   = 1'b0;
        pwm_inc     = {1'b0, r_pwm_count} + 9'd1;
        idle_inc    = r_idle + 8'd1;

        // The counter advances only while powered; it wraps on reaching the period.
        if (r_power) begin
            n_pwm_count = (pwm_inc >= {1'b0, r_pwm_period}) ? 8'd0 : pwm_inc[7:0];
        end

        if (i_in_ch.slow_tick) begin
            if (i_in_ch.key_pressed) begin
                n_idle = 8'd0;
                n_hold = (r_hold < HOLD_LIMIT) ? r_hold + 8'd1 : HOLD_LIMIT;
            end else begin
                // A release after a long enough hold counts as one press.
                toggle = (r_hold >= r_debounce_ticks);
                n_hold = 8'd0;
            end
        end

        n_power = r_power ^ toggle;

        // A toggle restarts the run from a cleared phase and counter.
        if (toggle) begin
            n_pwm_count = 8'd0;
            n_slot      = '0;
            n_offset    = '0;
        end

        sched_en = i_in_ch.slow_tick && n_power;
        if (sched_en) begin
            if (n_offset == SLOT_LAST) begin
                n_offset = '0;
                n_slot   = (n_slot == SLOT_W'(LED_CHANNELS - 1)) ? '0 : n_slot + 1'b1;
            end else begin
                n_offset = n_offset + 1'b1;
            end
        end

        // While off and with the key up, idle ticks run toward a sleep request.
        if (i_in_ch.slow_tick && !n_power && (n_hold == 8'd0)) begin
            if (idle_inc > r_sleep_ticks) begin
                sleep_req = 1'b1;
                n_idle    = 8'd0;
            end else begin
                n_idle = idle_inc;
            end
        end

        in_ramp_up = (n_offset < RAMP_TICKS);
        in_hold    = (n_offset < HOLD_END);
    end

    // Per-channel duty update. A ramp up in slot 0 clears every other channel,
    // and in any later slot clears the channel before it.
    for (genvar k = 0; k < LED_CHANNELS; k++) begin : g_duty
        logic [7:0] base;
        logic       own_slot;
        logic       clr_hit;

        assign base     = toggle ? 8'd0 : r_duty[k];
        assign own_slot = (n_slot == SLOT_W'(k));
        assign clr_hit  = ((n_slot == '0) && (k != 0))
                       || ({1'b0, n_slot} == (SLOT_W + 1)'(k + 1));

        always_comb begin
            n_duty[k] = base;
            if (sched_en) begin
                if (in_ramp_up) begin
                    if (clr_hit) begin
                        n_duty[k] = 8'd0;
                    end else if (own_slot && (base < r_max_duty)) begin
                        n_duty[k] = base + 8'd1;
                    end
                end else if (in_hold) begin
                    if (own_slot) begin
                        n_duty[k] = r_max_duty;
                    end
                end else if (own_slot && (base != 8'd0)) begin
                    n_duty[k] = base - 8'd1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_duty[k] <= 8'd0;
            end else if (in_fire) begin
                r_duty[k] <= n_duty[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_count <= 8'd0;
            r_slot      <= '0;
            r_offset    <= '0;
            r_power     <= 1'b0;
            r_hold      <= 8'd0;
            r_idle      <= 8'd0;
        end else if (in_fire) begin
            r_pwm_count <= n_pwm_count;
            r_slot      <= n_slot;
            r_offset    <= n_offset;
            r_power     <= n_power;
            r_hold      <= n_hold;
            r_idle      <= n_idle;
        end
    end

    assign result.led_mask      = led_mask;
    assign result.power_on      = n_power;
    assign result.sleep_request = sleep_req;

    lcfp_skid u_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_ch.valid),
        .o_push_ready (in_ready),
        .i_push_data  (result),
        .o_pop_valid  (o_out_ch.valid),
        .i_pop_ready  (o_out_ch.ready),
        .o_pop_data   (out_data)
    );

    assign o_out_ch.led_mask      = out_data.led_mask;
    assign o_out_ch.power_on      = out_data.power_on;
    assign o_out_ch.sleep_request = out_data.sleep_request;

endmodule

### rtl/lcfp_checker.sv
// Port-level checker for the LED chase controller, bound to the top level.
// Depends on the assertion macros header.
`timescale 1ns / 1ps
`include "led_chase_fade_pwm_controller_core_macros.svh"

module lcfp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_led_mask,
    input logic       i_power_on,
    input logic       i_sleep_request
);

    // A result beat held back by the sink keeps its valid and its contents.
    `LCFP_ASSERT(a_out_valid_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result valid dropped while stalled")
    `LCFP_ASSERT(a_out_data_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> ($stable(i_led_mask) && $stable(i_power_on) && $stable(i_sleep_request)), "stalled result changed")

    // Sleep is only ever requested with the chase powered off.
    `LCFP_ASSERT(a_sleep_only_off, i_clk, i_rst_n, (i_out_valid && i_sleep_request) |-> !i_power_on, "sleep request while powered")

    // Reset empties the result buffer.
    `LCFP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")

endmodule

bind led_chase_fade_pwm_controller_core lcfp_checker u_lcfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_ch.valid),
    .i_out_ready     (o_out_ch.ready),
    .i_led_mask      (o_out_ch.led_mask),
    .i_power_on      (o_out_ch.power_on),
    .i_sleep_request (o_out_ch.sleep_request)
);
